[hw/rtl/spr_pkg.sv]
// Shared types and constants for the stream pattern replace block.
`default_nettype none

package spr_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_W      = 4;

   typedef logic [BYTE_W-1:0] byte_type;

   localparam byte_type NEWLINE = 8'h0A;

   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES,
      CSR_PATTERN_LENGTH,
      CSR_REPLACEMENT_BYTES,
      CSR_REPLACEMENT_LENGTH
   } csr_index_type;

endpackage

`default_nettype wire

[hw/rtl/stream_pattern_replace.sv]
// Streaming find-and-replace-all over a byte stream, one text byte a beat.
//
// Each input beat carries one text byte, or an end-of-stream marker in tuser.
// Bytes wait in a window of up to MAX_PATTERN entries. When the window fills
// to the configured pattern length it either emits the replacement text and
// clears, or releases its oldest byte. A newline or an end-of-stream beat
// releases everything pending, so matches never cross a line. An input beat
// is processed in the cycle it is accepted; its result beats leave an output
// buffer from the next cycle on, one per cycle while rsp_tready is high, the
// last marked by rsp_tlast. A beat that yields at most one result is taken
// every cycle while rsp_tready is high; one that yields more holds the output
// buffer; the next input beat is accepted in the cycle its last result
// leaves. A pattern length of zero passes text straight through. Write the
// configuration registers only while no result beats are outstanding.
`default_nettype none

module stream_pattern_replace #(
   parameter int MAX_PATTERN     = 8,
   parameter int MAX_REPLACEMENT = 8
) (
   input  wire                              clock,
   input  wire                              reset,
   // request beats
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  spr_pkg::byte_type          req_tdata,   // [7:0] in_byte
   input  wire                              req_tuser,   // [0] flush
   // result beats
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output spr_pkg::byte_type                rsp_tdata,   // [7:0] out_byte
   output logic                             rsp_tlast,
   // configuration writes
   input  wire                              csr_wr_en,
   input  wire  spr_pkg::csr_index_type     csr_index,
   input  wire  [spr_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import spr_pkg::*;

   localparam int OUT_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
   localparam int CNT_W     = $clog2(MAX_PATTERN + 1);
   localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

   logic [CSR_DATA_W-1:0] pat_bytes_ff;
   logic [LEN_W-1:0]      pat_len_ff;
   logic [CSR_DATA_W-1:0] rep_bytes_ff;
   logic [LEN_W-1:0]      rep_len_ff;

   byte_type           win_ff  [MAX_PATTERN];
   byte_type           win_in  [MAX_PATTERN];
   logic [CNT_W-1:0]   cnt_ff;
   logic [CNT_W-1:0]   cnt_in;
   byte_type           obuf_ff [OUT_DEPTH];
   byte_type           obuf_in [OUT_DEPTH];
   logic [OCNT_W-1:0]  orem_ff;
   logic [OCNT_W-1:0]  orem_in;

   byte_type           win_app   [MAX_PATTERN];
   byte_type           win_shift [MAX_PATTERN];
   byte_type           win_short [MAX_PATTERN];
   byte_type           out_win   [OUT_DEPTH];
   byte_type           out_rep   [OUT_DEPTH];
   byte_type           obuf_next [OUT_DEPTH];
   logic [MAX_PATTERN-1:0] match_bit;

   logic [CNT_W-1:0]   plen;
   logic [OCNT_W-1:0]  rlen;
   logic [CNT_W-1:0]   cnt_plus;
   logic [CNT_W-1:0]   short_place;
   logic               take_two;
   logic               req_accept;
   logic               rsp_beat;
   logic               is_newline;

   assign plen = (pat_len_ff > LEN_W'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN)
                                                    : CNT_W'(pat_len_ff);
   assign rlen = (rep_len_ff > LEN_W'(MAX_REPLACEMENT)) ? OCNT_W'(MAX_REPLACEMENT)
                                                        : OCNT_W'(rep_len_ff);

   assign rsp_tvalid = (orem_ff != '0);
   assign rsp_tlast  = (orem_ff == OCNT_W'(1));
   assign rsp_tdata  = obuf_ff[0];
   assign rsp_beat   = rsp_tvalid && rsp_tready;
   assign req_tready = (orem_ff == '0) || (rsp_tlast && rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign is_newline  = (req_tdata == NEWLINE);
   assign cnt_plus    = cnt_ff + CNT_W'(1);
   assign take_two    = (cnt_ff > CNT_W'(1));
   assign short_place = take_two ? (cnt_ff - CNT_W'(2)) : (cnt_ff - CNT_W'(1));

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : gen_win
      assign win_app[i]   = (CNT_W'(i) == cnt_ff) ? req_tdata : win_ff[i];
      assign match_bit[i] = (CNT_W'(i) >= plen) ||
                            (win_app[i] == pat_bytes_ff[BYTE_W*i +: BYTE_W]);
      if (i + 2 < MAX_PATTERN) begin : gen_two
         assign win_short[i] = (CNT_W'(i) == short_place) ? req_tdata :
                               (take_two ? win_ff[i+2] : win_ff[i+1]);
      end else if (i + 1 < MAX_PATTERN) begin : gen_one
         assign win_short[i] = (CNT_W'(i) == short_place) ? req_tdata :
                               (take_two ? '0 : win_ff[i+1]);
      end else begin : gen_end
         assign win_short[i] = (CNT_W'(i) == short_place) ? req_tdata : '0;
      end
      if (i + 1 < MAX_PATTERN) begin : gen_sh
         assign win_shift[i] = win_app[i+1];
      end else begin : gen_sh_end
         assign win_shift[i] = '0;
      end
   end

   for (genvar j = 0; j < OUT_DEPTH; j++) begin : gen_out
      if (j < MAX_PATTERN) begin : gen_w
         assign out_win[j] = win_app[j];
      end else begin : gen_w_pad
         assign out_win[j] = '0;
      end
      if (j < MAX_REPLACEMENT) begin : gen_r
         assign out_rep[j] = rep_bytes_ff[BYTE_W*j +: BYTE_W];
      end else begin : gen_r_pad
         assign out_rep[j] = '0;
      end
      if (j + 1 < OUT_DEPTH) begin : gen_o
         assign obuf_next[j] = obuf_ff[j+1];
      end else begin : gen_o_end
         assign obuf_next[j] = '0;
      end
   end

   always_comb begin
      win_in  = win_ff;
      cnt_in  = cnt_ff;
      obuf_in = obuf_ff;
      orem_in = orem_ff;
      if (rsp_beat) begin
         obuf_in = obuf_next;
         orem_in = orem_ff - OCNT_W'(1);
      end
      if (req_accept) begin
         obuf_in = out_win;
         orem_in = '0;
         priority if (req_tuser) begin
            orem_in = OCNT_W'(cnt_ff);
            cnt_in  = '0;
         end else if (is_newline || (plen == '0)) begin
            orem_in = OCNT_W'(cnt_ff) + OCNT_W'(1);
            cnt_in  = '0;
         end else if (cnt_ff >= plen) begin
            orem_in = take_two ? OCNT_W'(2) : OCNT_W'(1);
            win_in  = win_short;
            cnt_in  = take_two ? (cnt_ff - CNT_W'(1)) : cnt_ff;
         end else if (cnt_plus == plen) begin
            if (&match_bit) begin
               obuf_in = out_rep;
               orem_in = rlen;
               cnt_in  = '0;
            end else begin
               orem_in = OCNT_W'(1);
               win_in  = win_shift;
               cnt_in  = cnt_ff;
            end
         end else begin
            win_in = win_app;
            cnt_in = cnt_plus;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         orem_ff      <= '0;
         pat_bytes_ff <= '0;
         pat_len_ff   <= '0;
         rep_bytes_ff <= '0;
         rep_len_ff   <= '0;
      end else begin
         cnt_ff  <= cnt_in;
         orem_ff <= orem_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_PATTERN_BYTES:      pat_bytes_ff <= csr_wdata;
               CSR_PATTERN_LENGTH:     pat_len_ff   <= csr_wdata[LEN_W-1:0];
               CSR_REPLACEMENT_BYTES:  rep_bytes_ff <= csr_wdata;
               CSR_REPLACEMENT_LENGTH: rep_len_ff   <= csr_wdata[LEN_W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      obuf_ff <= obuf_in;
   end

   a_window_never_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(MAX_PATTERN))
      else $error("pending window reached its full depth");

   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_tuser |=> cnt_ff == '0)
      else $error("end-of-stream beat left bytes pending");

   a_accept_when_drained: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (orem_ff == '0) || rsp_beat && rsp_tlast)
      else $error("request accepted over undelivered results");

   a_newline_emits: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_tuser && is_newline |=> rsp_tvalid)
      else $error("newline beat produced no result");

endmodule

`default_nettype wire
